// ===== sv/soa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 13;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOOLARGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUST  = 3'd3;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam int KIND_FULL    = 0;
    localparam int KIND_PARTIAL = 1;
    localparam int KIND_FREE    = 2;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] object_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [STAT_W-1:0] status;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_ALLOC, S_ALLOC_PICK, S_CLAIM_INIT, S_CLAIM_LINK, S_POP_RD, S_POP,
        S_FREE_CHK, S_FREE_PUSH, S_UNLINK, S_UNLINK2, S_PUSH, S_PUSH2,
        S_ADDR, S_DONE
    } t_state;

endpackage

// ===== sv/soa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface soa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/soa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_front
// Accepts requests and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module soa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    soa_if.sink           s_in,
    output logic          o_valid,
    output soa_pkg::t_req o_req,
    input  logic          i_take
);
    import soa_pkg::*;

    t_req       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_pop;

    assign s_in.ready = (r_cnt != 2'd2);
    assign w_push     = s_in.valid && s_in.ready;
    assign w_pop      = i_take && (r_cnt != 2'd0);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_req      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= s_in.data;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== sv/soa_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_engine
// Slab engine: classifies a request, walks the page lists and slot links,
// and delivers one response through an output register.
// ----------------------------------------------------------------------------
module soa_engine #(
    parameter int POOL_PAGES       = 64,
    parameter int PAGE_BYTES       = 4096,
    parameter int HEADER_BYTES     = 40,
    parameter int SIZE_CLASSES     = 10,
    parameter int MIN_OBJECT_BYTES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_enabled,
    input  logic [soa_pkg::ADDR_W-1:0] i_base,
    input  logic                      i_valid,
    input  soa_pkg::t_req             i_req,
    output logic                      o_take,
    soa_if.source                     m_out
);
    import soa_pkg::*;

    localparam int PG_W   = $clog2(POOL_PAGES + 1);
    localparam int PIX_W  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int SLOTS  = PAGE_BYTES / MIN_OBJECT_BYTES;
    localparam int SL_W   = $clog2(SLOTS + 1);
    localparam int SIX_W  = $clog2(SLOTS);
    localparam int CL_W   = $clog2(SIZE_CLASSES + 1);
    localparam int HD_N   = SIZE_CLASSES * 3;
    localparam int HIX_W  = (HD_N > 1) ? $clog2(HD_N) : 1;
    localparam int PB_W   = $clog2(PAGE_BYTES);
    localparam int MB_W   = $clog2(MIN_OBJECT_BYTES);
    localparam int PAYLOAD_BYTES = PAGE_BYTES - HEADER_BYTES;
    localparam logic [PG_W-1:0] PG_NONE = '1;
    localparam logic [SL_W-1:0] SL_NONE = '1;

    // Class sizes are powers of two, so the slot count is a shift.
    function automatic logic [SL_W-1:0] slots_of(input logic [CL_W-1:0] c);
        logic [SL_W-1:0] r;
        r = '0;
        for (int k = 0; k < SIZE_CLASSES; k++) begin
            if (c == CL_W'(k)) r = SL_W'(PAYLOAD_BYTES >> (MB_W + k));
        end
        return r;
    endfunction

    // Per-page tables and the slot link memory.
    logic [CL_W-1:0] m_cls  [POOL_PAGES];
    logic [SL_W-1:0] m_use  [POOL_PAGES];
    logic [SL_W-1:0] m_head [POOL_PAGES];
    logic [PG_W-1:0] m_prev [POOL_PAGES];
    logic [PG_W-1:0] m_next [POOL_PAGES];
    logic [SL_W-1:0] m_link [POOL_PAGES*SLOTS];
    logic [PG_W-1:0] r_lhead [HD_N];
    logic [HD_N-1:0] r_lval;

    t_state r_st, n_st;
    t_req   r_req;
    t_rsp   r_rsp;
    logic   r_ovld;
    logic [PG_W-1:0]  r_claimed, r_pg, r_p, r_n;
    logic [CL_W-1:0]  r_c;
    logic [SL_W-1:0]  r_cnt, r_s, r_i, r_use, r_head, r_rd;
    logic [1:0]       r_kind;
    logic             r_isfree;
    logic [ADDR_W-1:0] r_off;

    logic [PIX_W-1:0] w_pix;
    logic [HIX_W-1:0] w_hp, w_hf;
    logic [PG_W-1:0]  w_hpv, w_hfv;
    logic [CL_W-1:0]  w_cls;
    logic [1:0]       w_need;
    logic [ADDR_W-1:0] w_rel;
    logic [SL_W-1:0]  w_slot;
    logic              w_aligned;
    logic              w_refused, w_too_big, w_pool_full, w_pop_bad;
    logic              w_free_miss, w_free_bad;

    assign w_pix = r_pg[PIX_W-1:0];
    assign w_hp  = HIX_W'(r_c * 3 + KIND_PARTIAL);
    assign w_hf  = HIX_W'(r_c * 3 + KIND_FREE);
    assign w_hpv = r_lval[w_hp] ? r_lhead[w_hp] : PG_NONE;
    assign w_hfv = r_lval[w_hf] ? r_lhead[w_hf] : PG_NONE;
    assign o_take = (r_st == S_IDLE) && !r_ovld;
    assign m_out.valid = r_ovld;
    assign m_out.data  = r_rsp;

    // Smallest class that holds the size.
    always_comb begin
        w_cls = CL_W'(SIZE_CLASSES);
        for (int k = SIZE_CLASSES - 1; k >= 0; k--) begin
            if ({19'd0, r_req.request_size} <= 32'(MIN_OBJECT_BYTES << k)) w_cls = CL_W'(k);
        end
    end

    // Free address decode on the page offset.
    assign w_rel  = {{(ADDR_W-PB_W){1'b0}}, r_off[PB_W-1:0]} - ADDR_W'(HEADER_BYTES);
    assign w_slot = SL_W'(w_rel >> (MB_W + 32'(r_c)));
    always_comb begin
        w_aligned = 1'b1;
        for (int k = 0; k < PB_W; k++) begin
            if (k < MB_W + 32'(r_c) && w_rel[k]) w_aligned = 1'b0;
        end
    end
    assign w_need = r_isfree ? ((r_use == SL_W'(1)) ? 2'(KIND_FREE) : 2'(KIND_PARTIAL))
                             : ((r_use + 1'b1 >= r_cnt) ? 2'(KIND_FULL) : 2'(KIND_PARTIAL));

    assign w_refused   = !i_enabled || (r_req.request_size == '0);
    assign w_too_big   = (r_c >= CL_W'(SIZE_CLASSES)) || (r_cnt == '0);
    assign w_pool_full = r_claimed >= PG_W'(POOL_PAGES);
    assign w_pop_bad   = (r_s == SL_NONE) || (r_s >= r_cnt);
    assign w_free_miss = (r_req.object_address == '0) ||
                         ((r_off >> PB_W) >= ADDR_W'(r_claimed));
    assign w_free_bad  = (r_off[PB_W-1:0] < PB_W'(HEADER_BYTES)) || !w_aligned ||
                         (w_slot >= r_cnt) ||
                         ((w_rel >> (MB_W + 32'(r_c))) >= ADDR_W'(r_cnt)) ||
                         (r_use == '0);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:       if (i_valid && !r_ovld) n_st = i_req.action ? S_FREE_CHK : S_ALLOC;
            S_ALLOC:      n_st = S_ALLOC_PICK;
            S_ALLOC_PICK: begin
                if (w_refused || w_too_big) n_st = S_DONE;
                else if (w_hpv != PG_NONE || w_hfv != PG_NONE) n_st = S_POP_RD;
                else if (w_pool_full) n_st = S_DONE;
                else n_st = S_CLAIM_INIT;
            end
            S_CLAIM_INIT: if (r_i + 1'b1 == r_cnt) n_st = S_CLAIM_LINK;
            S_CLAIM_LINK: n_st = S_POP_RD;
            S_POP_RD:     n_st = S_POP;
            S_POP:        n_st = w_pop_bad ? S_DONE : S_UNLINK;
            S_FREE_CHK:   n_st = w_free_miss ? S_DONE : S_FREE_PUSH;
            S_FREE_PUSH:  n_st = w_free_bad ? S_DONE : S_UNLINK;
            S_UNLINK:     n_st = S_UNLINK2;
            S_UNLINK2:    n_st = S_PUSH;
            S_PUSH:       n_st = S_PUSH2;
            S_PUSH2:      n_st = r_isfree ? S_DONE : S_ADDR;
            S_ADDR:       n_st = S_DONE;
            S_DONE:       n_st = S_IDLE;
            default:      n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ovld    <= 1'b0;
            r_claimed <= '0;
            r_lval    <= '0;
        end else begin
            if (r_ovld && m_out.ready) r_ovld <= 1'b0;
            r_st <= n_st;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && !r_ovld) begin
                        r_req    <= i_req;
                        r_isfree <= i_req.action;
                        r_off    <= i_req.object_address - i_base;
                        r_rsp    <= '0;
                    end
                end
                S_ALLOC: begin
                    r_c   <= w_cls;
                    r_cnt <= slots_of(w_cls);
                end
                S_ALLOC_PICK: begin
                    if (w_refused) begin
                        r_rsp.status <= ST_REFUSED;
                    end else if (w_too_big) begin
                        r_rsp.status <= ST_TOOLARGE;
                    end else if (w_hpv != PG_NONE) begin
                        r_pg <= w_hpv;
                    end else if (w_hfv != PG_NONE) begin
                        r_pg <= w_hfv;
                    end else if (w_pool_full) begin
                        r_rsp.status <= ST_EXHAUST;
                    end else begin
                        r_pg      <= r_claimed;
                        r_claimed <= r_claimed + 1'b1;
                        r_i       <= '0;
                    end
                end
                S_CLAIM_INIT: begin
                    // One slot link per cycle, descending chain.
                    m_link[{w_pix, r_i[SIX_W-1:0]}] <= (r_i == '0) ? SL_NONE : r_i - 1'b1;
                    r_i <= r_i + 1'b1;
                end
                S_CLAIM_LINK: begin
                    m_cls[w_pix]  <= r_c;
                    m_use[w_pix]  <= '0;
                    m_head[w_pix] <= r_cnt - 1'b1;
                    m_next[w_pix] <= w_hfv;
                    m_prev[w_pix] <= PG_NONE;
                    if (w_hfv != PG_NONE) m_prev[w_hfv[PIX_W-1:0]] <= r_pg;
                    r_lhead[w_hf] <= r_pg;
                    r_lval[w_hf]  <= 1'b1;
                end
                S_POP_RD: begin
                    r_s    <= m_head[w_pix];
                    r_use  <= m_use[w_pix];
                    r_p    <= m_prev[w_pix];
                    r_n    <= m_next[w_pix];
                end
                S_POP: begin
                    if (w_pop_bad) begin
                        r_rsp.status <= ST_EXHAUST;
                    end else begin
                        r_rd   <= m_link[{w_pix, r_s[SIX_W-1:0]}];
                        r_kind <= (r_use == '0) ? 2'(KIND_FREE) :
                                  (r_use >= r_cnt) ? 2'(KIND_FULL) : 2'(KIND_PARTIAL);
                    end
                end
                S_FREE_CHK: begin
                    r_pg <= PG_W'(r_off >> PB_W);
                    if (w_free_miss) begin
                        r_rsp.status <= ST_IGNORED;
                    end else begin
                        r_c   <= m_cls[PIX_W'(r_off >> PB_W)];
                        r_cnt <= slots_of(m_cls[PIX_W'(r_off >> PB_W)]);
                        r_use <= m_use[PIX_W'(r_off >> PB_W)];
                        r_head <= m_head[PIX_W'(r_off >> PB_W)];
                        r_p   <= m_prev[PIX_W'(r_off >> PB_W)];
                        r_n   <= m_next[PIX_W'(r_off >> PB_W)];
                    end
                end
                S_FREE_PUSH: begin
                    if (w_free_bad) begin
                        r_rsp.status <= ST_IGNORED;
                    end else begin
                        m_link[{w_pix, w_slot[SIX_W-1:0]}] <= r_head;
                        m_head[w_pix] <= w_slot;
                        r_kind <= (r_use >= r_cnt) ? 2'(KIND_FULL) : 2'(KIND_PARTIAL);
                    end
                end
                S_UNLINK: begin
                    // An allocation advances the free-slot head to the popped link.
                    if (!r_isfree) m_head[w_pix] <= r_rd;
                    if (r_p == PG_NONE) begin
                        r_lhead[HIX_W'(r_c * 3 + r_kind)] <= r_n;
                        r_lval[HIX_W'(r_c * 3 + r_kind)]  <= 1'b1;
                    end else begin
                        m_next[r_p[PIX_W-1:0]] <= r_n;
                    end
                end
                S_UNLINK2: begin
                    if (r_n != PG_NONE) m_prev[r_n[PIX_W-1:0]] <= r_p;
                    m_use[w_pix] <= r_isfree ? r_use - 1'b1 : r_use + 1'b1;
                    r_kind <= w_need;
                end
                S_PUSH: begin
                    r_n <= r_lval[HIX_W'(r_c * 3 + r_kind)] ?
                           r_lhead[HIX_W'(r_c * 3 + r_kind)] : PG_NONE;
                end
                S_PUSH2: begin
                    m_next[w_pix] <= r_n;
                    m_prev[w_pix] <= PG_NONE;
                    if (r_n != PG_NONE) m_prev[r_n[PIX_W-1:0]] <= r_pg;
                    r_lhead[HIX_W'(r_c * 3 + r_kind)] <= r_pg;
                    r_lval[HIX_W'(r_c * 3 + r_kind)]  <= 1'b1;
                    r_rsp.status <= ST_OK;
                end
                S_ADDR: begin
                    r_rsp.granted_address <= i_base + (ADDR_W'(r_pg) << PB_W) +
                        ADDR_W'(HEADER_BYTES) + (ADDR_W'(r_s) << (MB_W + 32'(r_c)));
                end
                S_DONE: r_ovld <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// ===== sv/slab_object_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator_top
// Slab allocator with power-of-two size classes over a pool of pages.
//
// channel  dir  payload
// s_in     in   action, request_size, object_address
// m_out    out  granted_address, status
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data (enabled, pool_base_address)
//
// An allocation picks a class and a page, pops a slot, relinks the page and
// forms the address; a free checks the page, pushes the slot and relinks the
// page; a refused or ignored request goes to its response. A page claim
// writes one slot link per cycle (up to 507 slots) and links the page. The
// engine holds one request until its response is taken; a two-entry queue in
// front accepts while not full. Reset is synchronous, emptying all class lists.
// ----------------------------------------------------------------------------
module slab_object_allocator_top #(
    parameter int POOL_PAGES       = 64,
    parameter int PAGE_BYTES       = 4096,
    parameter int HEADER_BYTES     = 40,
    parameter int SIZE_CLASSES     = 10,
    parameter int MIN_OBJECT_BYTES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [soa_pkg::ADDR_W-1:0] i_cfg_data,
    soa_if.sink                       s_in,
    soa_if.source                     m_out
);
    import soa_pkg::*;

    localparam logic CFG_ENABLED = 1'b0;
    localparam logic CFG_BASE    = 1'b1;

    logic              r_enabled;
    logic [ADDR_W-1:0] r_base;
    logic              w_valid, w_take;
    t_req              w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_base    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ENABLED) r_enabled <= i_cfg_data[0];
            if (i_cfg_idx == CFG_BASE) r_base <= i_cfg_data;
        end
    end

    soa_front u_front (
        .i_clk, .i_rst_n, .s_in,
        .o_valid(w_valid), .o_req(w_req), .i_take(w_take)
    );

    soa_engine #(
        .POOL_PAGES(POOL_PAGES), .PAGE_BYTES(PAGE_BYTES), .HEADER_BYTES(HEADER_BYTES),
        .SIZE_CLASSES(SIZE_CLASSES), .MIN_OBJECT_BYTES(MIN_OBJECT_BYTES)
    ) u_engine (
        .i_clk, .i_rst_n, .i_enabled(r_enabled), .i_base(r_base),
        .i_valid(w_valid), .i_req(w_req), .o_take(w_take), .m_out
    );
endmodule
